### design/llqm_pkg.sv
// Shared types, constants and the grading function for the link liveness monitor.
// No dependencies; imported by llqm_alu and link_liveness_and_quality_monitor.
`timescale 1ns / 1ps

package llqm_pkg;

    // slot table size
    localparam int PEER_SLOTS = 8;
    localparam int IDX_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int CNT_W      = $clog2(PEER_SLOTS + 1);
    localparam int SUM_W      = 16 + $clog2(PEER_SLOTS);
    localparam int STEP_W     = $clog2(SUM_W);

    // field widths
    localparam int CMD_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int PING_W  = 16;
    localparam int TIME_W  = 32;
    localparam int DELTA_W = 16;
    localparam int KIND_W  = 3;
    localparam int QUAL_W  = 3;
    localparam int ACC_W   = 17;
    localparam int TMO_W   = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int ALU_W   = 32;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PING    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONNECT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISC    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] EV_STATUS  = 3'd0;
    localparam logic [KIND_W-1:0] EV_CONN    = 3'd1;
    localparam logic [KIND_W-1:0] EV_DISC    = 3'd2;
    localparam logic [KIND_W-1:0] EV_TIMEOUT = 3'd3;
    localparam logic [KIND_W-1:0] EV_QUALITY = 3'd4;

    // quality levels
    localparam logic [QUAL_W-1:0] Q_EXCELLENT = 3'd0;
    localparam logic [QUAL_W-1:0] Q_GOOD      = 3'd1;
    localparam logic [QUAL_W-1:0] Q_FAIR      = 3'd2;
    localparam logic [QUAL_W-1:0] Q_POOR      = 3'd3;
    localparam logic [QUAL_W-1:0] Q_LOST      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACHED = 2'd1;

    localparam logic [ACC_W-1:0] SECOND_MS       = 17'd1000;
    localparam logic [TMO_W-1:0] TIMEOUT_RST     = 20'd15000;
    localparam logic [PING_W-1:0] GOOD_LIMIT     = 16'd30;
    localparam logic [PING_W-1:0] FAIR_LIMIT     = 16'd80;
    localparam logic [PING_W-1:0] POOR_LIMIT     = 16'd150;
    localparam logic [PING_W-1:0] LOST_LIMIT     = 16'd300;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             carry;   // on subtract: 1 when a >= b
        logic [ALU_W-1:0] res;
    } t_alu_rsp;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [QUAL_W-1:0] quality;
        logic [PING_W-1:0] mean;
        logic [PING_W-1:0] sping;
        logic              salive;
        logic              aalive;
        logic              last;
    } t_result;

    function automatic logic [QUAL_W-1:0] grade(input logic [PING_W-1:0] mean);
        logic [QUAL_W-1:0] q;
        begin
            if (mean < GOOD_LIMIT)      q = Q_EXCELLENT;
            else if (mean < FAIR_LIMIT) q = Q_GOOD;
            else if (mean < POOR_LIMIT) q = Q_FAIR;
            else if (mean < LOST_LIMIT) q = Q_POOR;
            else                        q = Q_LOST;
            return q;
        end
    endfunction

endpackage

### design/link_liveness_and_quality_monitor.sv
// Top level of the peer liveness and link quality monitor: sequencer, slot table,
// output register. Depends on llqm_pkg and llqm_alu.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | command, peer_slot, ping_ms, now_ms,
//          |           |                           | delta_ms
//  out     | output    | o_out_valid / i_out_ready | event_kind, event_slot, quality,
//          |           |                           | mean_ping, slot_ping, slot_alive,
//          |           |                           | all_alive, last
//  cfg     | input     | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
//  One item at a time; o_in_ready is high only while idle with no result pending. Plain
//  commands go through the command state and emit their results; an attached tick below
//  one second also passes the accumulate state. A tick reaching one second walks the slots
//  twice through the shared adder (scan and check states per slot for the timeout test,
//  the sum state for the ping sum) and then runs a restoring divide, one quotient bit per
//  cycle. Each result waits until the output register is free.
//  Reset is synchronous; no clearing pass is needed. cfg is always ready.

module link_liveness_and_quality_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [llqm_pkg::CMD_W-1:0]        i_command,
    input  logic [llqm_pkg::SLOT_W-1:0]       i_peer_slot,
    input  logic [llqm_pkg::PING_W-1:0]       i_ping_ms,
    input  logic [llqm_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [llqm_pkg::DELTA_W-1:0]      i_delta_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [llqm_pkg::KIND_W-1:0]       o_event_kind,
    output logic [llqm_pkg::SLOT_W-1:0]       o_event_slot,
    output logic [llqm_pkg::QUAL_W-1:0]       o_quality,
    output logic [llqm_pkg::PING_W-1:0]       o_mean_ping,
    output logic [llqm_pkg::PING_W-1:0]       o_slot_ping,
    output logic                              o_slot_alive,
    output logic                              o_all_alive,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [llqm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [llqm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import llqm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_CMD      = 11'b00000000010,
        S_EMIT_CMD = 11'b00000000100,
        S_ACC      = 11'b00000001000,
        S_SCAN     = 11'b00000010000,
        S_CHK      = 11'b00000100000,
        S_TO_DISC  = 11'b00001000000,
        S_TO_TMO   = 11'b00010000000,
        S_SUM      = 11'b00100000000,
        S_DIV      = 11'b01000000000,
        S_GRADE    = 11'b10000000000
    } t_state;

    // status and quality results share the output phase below
    typedef enum logic [2:0] {
        P_NONE   = 3'b001,
        P_QUAL   = 3'b010,
        P_STATUS = 3'b100
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    // configuration
    logic [TMO_W-1:0] r_timeout;
    logic             r_attached;

    // latched item
    logic [CMD_W-1:0]   r_cmd;
    logic [SLOT_W-1:0]  r_slot;
    logic [PING_W-1:0]  r_ping;
    logic [TIME_W-1:0]  r_now;
    logic [DELTA_W-1:0] r_delta;

    // slot table
    logic [PING_W-1:0] r_ping_value [PEER_SLOTS];
    logic [TIME_W-1:0] r_seen_time  [PEER_SLOTS];
    logic [PEER_SLOTS-1:0] r_ping_valid;
    logic [PEER_SLOTS-1:0] r_seen_valid;
    logic [PEER_SLOTS-1:0] r_dropped;
    logic [ACC_W-1:0]  r_acc;
    logic [QUAL_W-1:0] r_quality;
    logic              r_any_joined;

    // sequencer working registers
    logic [IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0] r_elapsed;
    logic [SUM_W-1:0]  r_sum;      // ping sum, then dividend / quotient
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;

    t_result r_out;
    logic    r_out_valid;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic              out_free;
    logic              in_acc;
    logic              slot_ok;
    logic [IDX_W-1:0]  slot_ix;
    logic [IDX_W-1:0]  rd_ix;
    logic [PING_W-1:0] rd_ping;
    logic              idx_last;
    logic              hit;
    logic [CNT_W:0]    div_shift;
    logic [QUAL_W-1:0] new_q;
    logic [CNT_W-1:0]  cnt_next;
    logic [SUM_W-1:0]  sum_next;
    logic              q_bit;
    t_result           status_res;
    t_result           qual_res;
    logic              out_load;
    t_result           out_data;

    llqm_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && (r_phase == P_NONE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign slot_ok  = (32'(r_slot) < PEER_SLOTS);
    assign slot_ix  = IDX_W'(r_slot);
    assign idx_last = (r_idx == IDX_W'(PEER_SLOTS - 1));

    // single read port on the ping table: scan index during the sum, else input slot
    assign rd_ix   = (r_state == S_SUM) ? r_idx : slot_ix;
    assign rd_ping = r_ping_value[rd_ix];

    assign div_shift = {r_rem, r_sum[SUM_W-1]};
    assign new_q     = grade(r_sum[PING_W-1:0]);
    assign hit       = r_seen_valid[r_idx] && !r_dropped[r_idx] && !alu_rsp.carry;
    assign q_bit     = alu_rsp.carry;
    assign sum_next  = alu_rsp.res[SUM_W-1:0];
    assign cnt_next  = r_cnt + CNT_W'(r_ping_valid[r_idx]);

    always_comb begin
        alu_req = '0;
        unique case (r_state)
            S_ACC: begin
                alu_req.a = ALU_W'(r_acc);
                alu_req.b = ALU_W'(r_delta);
            end
            S_SCAN: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_now;
                alu_req.b   = r_seen_time[r_idx];
            end
            S_CHK: begin
                // borrow means elapsed exceeds the timeout
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(r_timeout);
                alu_req.b   = r_elapsed;
            end
            S_SUM: begin
                alu_req.a = ALU_W'(r_sum);
                alu_req.b = r_ping_valid[r_idx] ? ALU_W'(rd_ping) : '0;
            end
            S_DIV: begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(div_shift);
                alu_req.b   = ALU_W'(r_cnt);
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        status_res         = '0;
        status_res.kind    = EV_STATUS;
        status_res.slot    = r_slot;
        status_res.quality = r_quality;
        status_res.sping   = (slot_ok && r_ping_valid[slot_ix]) ? rd_ping : '0;
        status_res.salive  = slot_ok ? !r_dropped[slot_ix] : 1'b1;
        status_res.aalive  = !(|r_dropped) && r_any_joined;
        status_res.last    = 1'b1;

        qual_res         = '0;
        qual_res.kind    = EV_QUALITY;
        qual_res.slot    = r_slot;
        qual_res.quality = new_q;
        qual_res.mean    = r_sum[PING_W-1:0];
    end

    // result to load into the output register this cycle
    always_comb begin
        out_load         = 1'b0;
        out_data         = '0;
        out_data.quality = r_quality;
        unique case (r_state)
            S_IDLE: begin
                if (r_phase != P_NONE) begin
                    out_load = out_free;
                    out_data = (r_phase == P_QUAL) ? qual_res : status_res;
                end
            end
            S_EMIT_CMD: begin
                out_load      = out_free;
                out_data.kind = (r_cmd == CMD_CONNECT) ? EV_CONN : EV_DISC;
                out_data.slot = r_slot;
            end
            S_TO_DISC, S_TO_TMO: begin
                out_load      = out_free;
                out_data.kind = (r_state == S_TO_DISC) ? EV_DISC : EV_TIMEOUT;
                out_data.slot = SLOT_W'(r_idx);
            end
            default: ;
        endcase
    end

    // payload stores, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_command;
            r_slot  <= i_peer_slot;
            r_ping  <= i_ping_ms;
            r_now   <= i_now_ms;
            r_delta <= i_delta_ms;
        end
        if (r_state == S_CMD && slot_ok) begin
            if (r_cmd == CMD_PING) begin
                r_ping_value[slot_ix] <= r_ping;
                r_seen_time[slot_ix]  <= r_now;
            end else if (r_cmd == CMD_CONNECT) begin
                r_seen_time[slot_ix]  <= r_now;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
            r_out       <= out_data;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= P_NONE;
            r_timeout    <= TIMEOUT_RST;
            r_attached   <= 1'b0;
            r_ping_valid <= '0;
            r_seen_valid <= '0;
            r_dropped    <= '0;
            r_acc        <= '0;
            r_quality    <= Q_EXCELLENT;
            r_any_joined <= 1'b0;
            r_idx        <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_rem        <= '0;
            r_step       <= '0;
            r_elapsed    <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TMO_W-1:0];
                    CFG_ATTACHED: r_attached <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_CMD;
                    end else if (r_phase != P_NONE && out_free) begin
                        // result phases run from idle once the working states are done
                        if (r_phase == P_QUAL) begin
                            r_quality <= new_q;
                            r_phase   <= P_STATUS;
                        end else begin
                            r_phase <= P_NONE;
                        end
                    end
                end
                S_CMD: begin
                    if (r_cmd == CMD_TICK && r_attached) begin
                        r_state <= S_ACC;
                    end else if (slot_ok && (r_cmd inside {CMD_CONNECT, CMD_DISC})) begin
                        r_state <= S_EMIT_CMD;
                    end else begin
                        r_state <= S_IDLE;
                        r_phase <= P_STATUS;
                    end
                    if (r_cmd == CMD_RESET) begin
                        r_ping_valid <= '0;
                        r_seen_valid <= '0;
                        r_dropped    <= '0;
                        r_acc        <= '0;
                        r_quality    <= Q_EXCELLENT;
                        r_any_joined <= 1'b0;
                    end else if (slot_ok) begin
                        case (r_cmd)
                            CMD_PING: begin
                                r_ping_valid[slot_ix] <= 1'b1;
                                r_seen_valid[slot_ix] <= 1'b1;
                                r_dropped[slot_ix]    <= 1'b0;
                            end
                            CMD_CONNECT: begin
                                r_any_joined          <= 1'b1;
                                r_seen_valid[slot_ix] <= 1'b1;
                                r_dropped[slot_ix]    <= 1'b0;
                            end
                            CMD_DISC: begin
                                r_dropped[slot_ix] <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EMIT_CMD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        r_phase <= P_STATUS;
                    end
                end
                S_ACC: begin
                    if (alu_rsp.res[ACC_W-1:0] < SECOND_MS) begin
                        r_acc   <= alu_rsp.res[ACC_W-1:0];
                        r_state <= S_IDLE;
                        r_phase <= P_STATUS;
                    end else begin
                        r_acc   <= '0;
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_elapsed <= alu_rsp.res;
                    r_state   <= S_CHK;
                end
                S_CHK: begin
                    if (hit) begin
                        r_state <= S_TO_DISC;
                    end else if (idx_last) begin
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_TO_DISC: begin
                    if (out_free) begin
                        r_dropped[r_idx] <= 1'b1;
                        r_state          <= S_TO_TMO;
                    end
                end
                S_TO_TMO: begin
                    if (out_free) begin
                        if (idx_last) begin
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_SUM;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SUM: begin
                    r_sum <= sum_next;
                    r_cnt <= cnt_next;
                    if (idx_last) begin
                        r_idx <= '0;
                        if (cnt_next == '0) begin
                            // no pings recorded: quality stays
                            r_state <= S_IDLE;
                            r_phase <= P_STATUS;
                        end else begin
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DIV: begin
                    // restoring divide, dividend shifts out as quotient shifts in
                    r_rem  <= q_bit ? alu_rsp.res[CNT_W-1:0] : div_shift[CNT_W-1:0];
                    r_sum  <= {r_sum[SUM_W-2:0], q_bit};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_GRADE;
                    end
                end
                S_GRADE: begin
                    r_state <= S_IDLE;
                    r_phase <= (new_q != r_quality) ? P_QUAL : P_STATUS;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out.kind;
    assign o_event_slot = r_out.slot;
    assign o_quality    = r_out.quality;
    assign o_mean_ping  = r_out.mean;
    assign o_slot_ping  = r_out.sping;
    assign o_slot_alive = r_out.salive;
    assign o_all_alive  = r_out.aalive;
    assign o_last       = r_out.last;

endmodule

### design/llqm_alu.sv
// Shared 32-bit add/subtract unit used by the monitor's sequencer.
// Depends on llqm_pkg for the request and response structs.
`timescale 1ns / 1ps

module llqm_alu (
    input  llqm_pkg::t_alu_req i_req,
    output llqm_pkg::t_alu_rsp o_rsp
);
    import llqm_pkg::*;

    logic [ALU_W-1:0] operand_b;
    logic [ALU_W:0]   total;

    assign operand_b = i_req.sub ? ~i_req.b : i_req.b;
    assign total     = {1'b0, i_req.a} + {1'b0, operand_b} + {{ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.carry = total[ALU_W];
    assign o_rsp.res   = total[ALU_W-1:0];

endmodule
